// ===== hdl/ddo_pkg.sv =====
// Shared types and fixed constants of the differential drive odometry block.
`default_nettype none
package ddo_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CNT_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_OFFSET  = 3'd4;

  localparam int Q_PI      = 205887;
  localparam int Q_HALF_PI = 102944;
  localparam int Q_TWO_PI  = 411775;
  localparam logic [31:0] CORDIC_K_Q30 = 32'd652032875;

  // Bias of 2^13 turns that makes any new heading sum nonnegative.
  localparam logic [33:0] MOD_BIAS     = 34'd3373260800;
  localparam logic [CNT_W-1:0] MOD_TOP_STEP = 5'd13;

  localparam logic [31:0] ATAN_Q30 [0:23] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256, 32'd128
  };

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_CSTEP, OP_MVR, OP_SVR, OP_MVL, OP_SVL, OP_MW, OP_SW,
    OP_MEAN, OP_MVC, OP_SVC, OP_MXD, OP_SXD, OP_MVS, OP_SVS, OP_MYD, OP_SYD,
    OP_MHD, OP_SHD, OP_MSTEP, OP_FIN
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] idx;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/ddo_if.sv =====
// Stream interfaces for wheel count transactions and pose result transactions.
`default_nettype none
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_count;
  logic signed [15:0] right_count;
  logic        [15:0] elapsed_time;
  modport source (output valid, left_count, right_count, elapsed_time, input ready);
  modport sink (input valid, left_count, right_count, elapsed_time, output ready);
endinterface

interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [18:0] heading;
  logic signed [31:0] linear_speed;
  logic signed [31:0] angular_rate;
  logic               over_limit;
  modport source (output valid, pos_x, pos_y, heading, linear_speed, angular_rate,
                  over_limit, input ready);
  modport sink (input valid, pos_x, pos_y, heading, linear_speed, angular_rate,
                over_limit, output ready);
endinterface
`default_nettype wire

// ===== hdl/ddo_datapath.sv =====
// Odometry datapath: registers, CORDIC rotator, shared multiplier and heading reduction.
`default_nettype none
module ddo_datapath #(
  parameter int FRACTION_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  ddo_pkg::dp_cmd_t                 cmd,
  input  wire                              cfg_we,
  input  wire  [ddo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [15:0]                      cfg_data,
  input  wire  signed [15:0]               left_count,
  input  wire  signed [15:0]               right_count,
  input  wire  [15:0]                      elapsed_time,
  output logic signed [31:0]               pos_x,
  output logic signed [31:0]               pos_y,
  output logic signed [18:0]               heading,
  output logic signed [31:0]               linear_speed,
  output logic signed [31:0]               angular_rate,
  output logic                             over_limit
);
  import ddo_pkg::*;

  localparam int CW  = FRACTION_BITS + 4;
  localparam int BW  = (CW > 17) ? CW : 17;
  localparam int AW  = 35;
  localparam int PW  = AW + BW;
  localparam int SHL = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
  localparam int SHR = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;

  logic [14:0] speed_limit_r;
  logic [15:0] wheel_gain_r, wheel_offset_r, turn_gain_r, turn_offset_r;

  logic signed [15:0] l_r, r_r;
  logic [15:0]        dt_r;
  logic               over_r;
  logic signed [32:0] vr_r, vl_r, w_r, v_r;
  logic signed [33:0] t_r;
  logic signed [31:0] x_r, y_r;
  logic signed [18:0] hd_r;
  logic signed [CW-1:0] cx_r, cy_r, cz_r;
  logic               flip_r;
  logic signed [PW-1:0] p_r;
  logic [33:0]        mod_r;

  logic signed [16:0] ls, rs, in_ls, in_rs;
  logic [16:0]        abs_l, abs_r, in_abs_l, in_abs_r;
  logic signed [17:0] d;
  logic [17:0]        ad;
  logic signed [AW-1:0] op_a;
  logic signed [BW-1:0] op_b;
  logic signed [PW-1:0] rnd_f, rnd_16, p_f, p_16;
  logic [32:0]        mag;
  logic [32:0]        wmag;
  logic signed [33:0] sum_v;
  logic signed [34:0] sat_sum;
  logic signed [31:0] sat_val;
  logic signed [19:0] h2, h_fold;
  logic               fold;
  logic signed [CW-1:0] z_init, atan_v;
  logic signed [34:0] h_sum;
  logic [33:0]        thr;
  logic signed [18:0] hd_wrap;

  assign ls = {l_r[15], l_r};
  assign rs = {r_r[15], r_r};
  assign abs_l = ls[16] ? 17'(-ls) : 17'(ls);
  assign abs_r = rs[16] ? 17'(-rs) : 17'(rs);
  assign in_ls = {left_count[15], left_count};
  assign in_rs = {right_count[15], right_count};
  assign in_abs_l = in_ls[16] ? 17'(-in_ls) : 17'(in_ls);
  assign in_abs_r = in_rs[16] ? 17'(-in_rs) : 17'(in_rs);
  assign d  = 18'(rs) - 18'(ls);
  assign ad = d[17] ? 18'(-d) : 18'(d);

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.op)
      OP_MVR: begin
        op_a = AW'($signed({1'b0, abs_r}));
        op_b = BW'($signed({1'b0, wheel_gain_r}));
      end
      OP_MVL: begin
        op_a = AW'($signed({1'b0, abs_l}));
        op_b = BW'($signed({1'b0, wheel_gain_r}));
      end
      OP_MW: begin
        op_a = AW'($signed({1'b0, ad}));
        op_b = BW'($signed({1'b0, turn_gain_r}));
      end
      OP_MVC: begin
        op_a = AW'(v_r);
        op_b = BW'(flip_r ? -cx_r : cx_r);
      end
      OP_MVS: begin
        op_a = AW'(v_r);
        op_b = BW'(flip_r ? -cy_r : cy_r);
      end
      OP_MXD, OP_MYD: begin
        op_a = AW'(t_r);
        op_b = BW'($signed({1'b0, dt_r}));
      end
      OP_MHD: begin
        op_a = AW'(w_r);
        op_b = BW'($signed({1'b0, dt_r}));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Round to nearest with ties toward plus infinity.
  assign rnd_f  = $signed(PW'(1) << (FRACTION_BITS - 1));
  assign rnd_16 = $signed(PW'(1) << 15);
  assign p_f    = (p_r + rnd_f) >>> FRACTION_BITS;
  assign p_16   = (p_r + rnd_16) >>> 16;

  assign mag   = p_r[32:0] + {17'd0, wheel_offset_r};
  assign wmag  = {1'b0, 32'((p_r[32:0] + 33'd1) >> 1)} + {17'd0, turn_offset_r};
  assign sum_v = 34'(vr_r) + 34'(vl_r);

  // CORDIC start: fold the heading into the right half plane.
  assign h2 = {hd_r[18], hd_r};
  always_comb begin
    fold   = 1'b0;
    h_fold = h2;
    if (h2 > 20'sd102944) begin
      h_fold = h2 - 20'sd205887;
      fold   = 1'b1;
    end else if (h2 < -20'sd102944) begin
      h_fold = h2 + 20'sd205887;
      fold   = 1'b1;
    end
    if (FRACTION_BITS >= 16) begin
      z_init = CW'(h_fold) <<< SHL;
    end else begin
      z_init = CW'(h_fold >>> SHR);
    end
  end
  assign atan_v = $signed(CW'(ATAN_Q30[cmd.idx] >> (30 - FRACTION_BITS)));

  assign h_sum = 35'(hd_r) + 35'($signed(p_16[33:0])) + $signed({1'b0, MOD_BIAS});
  assign thr   = 34'(Q_TWO_PI) << cmd.idx;
  assign hd_wrap = (mod_r > 34'(Q_PI)) ? 19'(mod_r - 34'(Q_TWO_PI)) : 19'(mod_r);

  always_comb begin
    if (cmd.op == OP_SXD) begin
      sat_sum = 35'(x_r) + 35'($signed(p_16[33:0]));
    end else begin
      sat_sum = 35'(y_r) + 35'($signed(p_16[33:0]));
    end
    if (sat_sum > 35'sd2147483647) begin
      sat_val = 32'sh7fffffff;
    end else if (sat_sum < -35'sd2147483648) begin
      sat_val = 32'sh80000000;
    end else begin
      sat_val = sat_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_limit_r  <= 15'd50;
      wheel_gain_r   <= 16'd655;
      wheel_offset_r <= 16'd328;
      turn_gain_r    <= 16'd4129;
      turn_offset_r  <= 16'd164;
      x_r  <= '0;
      y_r  <= '0;
      hd_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SPEED_LIMIT:  speed_limit_r  <= cfg_data[14:0];
          REG_WHEEL_GAIN:   wheel_gain_r   <= cfg_data;
          REG_WHEEL_OFFSET: wheel_offset_r <= cfg_data;
          REG_TURN_GAIN:    turn_gain_r    <= cfg_data;
          REG_TURN_OFFSET:  turn_offset_r  <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_SXD: x_r <= sat_val;
        OP_SYD: y_r <= sat_val;
        OP_FIN: hd_r <= hd_wrap;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_r <= PW'(op_a) * PW'(op_b);
    case (cmd.op)
      OP_LOAD: begin
        l_r    <= left_count;
        r_r    <= right_count;
        dt_r   <= elapsed_time;
        over_r <= (in_abs_l >= {2'b0, speed_limit_r}) ||
                  (in_abs_r >= {2'b0, speed_limit_r});
        cx_r   <= $signed(CW'(CORDIC_K_Q30 >> (30 - FRACTION_BITS)));
        cy_r   <= '0;
        cz_r   <= z_init;
        flip_r <= fold;
      end
      OP_CSTEP: begin
        if (!cz_r[CW-1]) begin
          cx_r <= cx_r - (cy_r >>> cmd.idx);
          cy_r <= cy_r + (cx_r >>> cmd.idx);
          cz_r <= cz_r - atan_v;
        end else begin
          cx_r <= cx_r + (cy_r >>> cmd.idx);
          cy_r <= cy_r - (cx_r >>> cmd.idx);
          cz_r <= cz_r + atan_v;
        end
      end
      OP_SVR: vr_r <= (over_r || r_r == 16'sd0) ? 33'sd0 :
                      (r_r[15] ? -$signed(mag) : $signed(mag));
      OP_SVL: vl_r <= (over_r || l_r == 16'sd0) ? 33'sd0 :
                      (l_r[15] ? -$signed(mag) : $signed(mag));
      OP_SW:  w_r  <= (over_r || d == 18'sd0) ? 33'sd0 :
                      (d[17] ? -$signed(wmag) : $signed(wmag));
      // Halve the sum, truncating toward zero.
      OP_MEAN: v_r <= 33'((sum_v + (sum_v[33] ? 34'sd1 : 34'sd0)) >>> 1);
      OP_SVC, OP_SVS: t_r <= p_f[33:0];
      OP_SHD: mod_r <= h_sum[33:0];
      OP_MSTEP: begin
        if (mod_r >= thr) mod_r <= mod_r - thr;
      end
      // The result fields are held here so the next tick can run while they wait.
      OP_FIN: begin
        over_limit   <= over_r;
        linear_speed <= v_r[31:0];
        angular_rate <= w_r[31:0];
        pos_x        <= x_r;
        pos_y        <= y_r;
        heading      <= hd_wrap;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/ddo_ctrl.sv =====
// Odometry sequencer: steps the datapath through one tick and runs the handshakes.
`default_nettype none
module ddo_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire              out_ready,
  output ddo_pkg::dp_cmd_t cmd
);
  import ddo_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE = 21'h000001, S_CORD = 21'h000002, S_MVR = 21'h000004,
    S_SVR  = 21'h000008, S_MVL  = 21'h000010, S_SVL = 21'h000020,
    S_MW   = 21'h000040, S_SW   = 21'h000080, S_MEAN = 21'h000100,
    S_MVC  = 21'h000200, S_SVC  = 21'h000400, S_MXD = 21'h000800,
    S_SXD  = 21'h001000, S_MVS  = 21'h002000, S_SVS = 21'h004000,
    S_MYD  = 21'h008000, S_SYD  = 21'h010000, S_MHD = 21'h020000,
    S_SHD  = 21'h040000, S_MODS = 21'h080000, S_FIN = 21'h100000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NOP;
    cmd.idx       = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          cnt_nxt   = '0;
          state_nxt = S_CORD;
        end
      end
      S_CORD: begin
        cmd.op = OP_CSTEP;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_MVR;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_MVR:  begin cmd.op = OP_MVR;  state_nxt = S_SVR;  end
      S_SVR:  begin cmd.op = OP_SVR;  state_nxt = S_MVL;  end
      S_MVL:  begin cmd.op = OP_MVL;  state_nxt = S_SVL;  end
      S_SVL:  begin cmd.op = OP_SVL;  state_nxt = S_MW;   end
      S_MW:   begin cmd.op = OP_MW;   state_nxt = S_SW;   end
      S_SW:   begin cmd.op = OP_SW;   state_nxt = S_MEAN; end
      S_MEAN: begin cmd.op = OP_MEAN; state_nxt = S_MVC;  end
      S_MVC:  begin cmd.op = OP_MVC;  state_nxt = S_SVC;  end
      S_SVC:  begin cmd.op = OP_SVC;  state_nxt = S_MXD;  end
      S_MXD:  begin cmd.op = OP_MXD;  state_nxt = S_SXD;  end
      S_SXD:  begin cmd.op = OP_SXD;  state_nxt = S_MVS;  end
      S_MVS:  begin cmd.op = OP_MVS;  state_nxt = S_SVS;  end
      S_SVS:  begin cmd.op = OP_SVS;  state_nxt = S_MYD;  end
      S_MYD:  begin cmd.op = OP_MYD;  state_nxt = S_SYD;  end
      S_SYD:  begin cmd.op = OP_SYD;  state_nxt = S_MHD;  end
      S_MHD:  begin cmd.op = OP_MHD;  state_nxt = S_SHD;  end
      S_SHD: begin
        cmd.op    = OP_SHD;
        cnt_nxt   = MOD_TOP_STEP;
        state_nxt = S_MODS;
      end
      S_MODS: begin
        cmd.op = OP_MSTEP;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        // The result register is reloaded only once the previous transaction has left.
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/differential_drive_odometry_top.sv =====
// Top level of the differential drive wheel odometry block.
`default_nettype none
// Each input transaction carries left and right wheel counts and the tick length; one
// result transaction returns the updated pose, the linear speed, the angular rate and the
// over-limit flag. The operands are loaded at the accepting edge; the sequencer then runs
// the CORDIC iterations, eight products on the single shared multiplier with the averaging
// of the wheel speeds among them, a fourteen-step heading reduction and the result write.
// A new transaction is accepted as soon as the sequencer is idle, even while the last
// result still waits to be taken; that result stays unchanged until it is taken, and the
// next one waits behind it.
module differential_drive_odometry_top #(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire                           clk,
  input  wire                           rst_n,
  ddo_in_if.sink                        in_ch,
  ddo_out_if.source                     out_ch,
  input  wire                           cfg_we,
  input  wire  [ddo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [15:0]                   cfg_data
);
  import ddo_pkg::*;

  dp_cmd_t cmd;

  ddo_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  ddo_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .left_count   (in_ch.left_count),
    .right_count  (in_ch.right_count),
    .elapsed_time (in_ch.elapsed_time),
    .pos_x        (out_ch.pos_x),
    .pos_y        (out_ch.pos_y),
    .heading      (out_ch.heading),
    .linear_speed (out_ch.linear_speed),
    .angular_rate (out_ch.angular_rate),
    .over_limit   (out_ch.over_limit)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while a tick was in progress");

  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.heading <= 19'sd205887) && (out_ch.heading >= -19'sd205887))
    else $error("heading outside the wrapped range");

  a_result_follows_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result raised without a tick in progress");
`endif

endmodule
`default_nettype wire
